// File: rtl/core/mcss_pkg.sv
`timescale 1ns / 1ps

package mcss_pkg;

   // Sizes of the chain and of the probability format.
   localparam int MAX_STATES = 16;
   localparam int PROB_BITS = 16;
   localparam int STATE_BITS = $clog2(MAX_STATES);
   localparam int NUM_BITS = 5;
   localparam int SUM_BITS = PROB_BITS + STATE_BITS;

   // Transition table is addressed by {row, column}.
   localparam int TT_ADDR_BITS = 2 * STATE_BITS;
   localparam int TT_DEPTH = 1 << TT_ADDR_BITS;
   localparam int IT_DEPTH = 1 << STATE_BITS;

   // Request queue between the front and the back.
   localparam int FQ_DEPTH = 2;
   localparam int FQ_PTR_BITS = $clog2(FQ_DEPTH);

   // Width that holds both the register value and the state count.
   localparam int LIM_BITS = (STATE_BITS + 1 > NUM_BITS) ? STATE_BITS + 1 : NUM_BITS;
   localparam logic [STATE_BITS:0] STATE_LIMIT = (STATE_BITS + 1)'(MAX_STATES);
   localparam logic [NUM_BITS-1:0] NUM_STATES_RESET = NUM_BITS'(16);

   // Request kinds, encoded as the mode field.
   typedef enum logic [1:0] {
      OP_LOAD_TRANS = 2'd0,
      OP_LOAD_INIT  = 2'd1,
      OP_START      = 2'd2,
      OP_STEP       = 2'd3
   } op_type;

   // One classified request.
   typedef struct packed {
      op_type                 op;
      logic                   load_ok;
      logic [STATE_BITS-1:0]  row;
      logic [STATE_BITS-1:0]  col;
      logic [PROB_BITS-1:0]   prob;
      logic [PROB_BITS-1:0]   draw;
   } cmd_type;

   // Head of the request queue as seen by the back.
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } fq_head_type;

endpackage

// File: rtl/core/markov_chain_state_sampler_core.sv
`timescale 1ns / 1ps

// Markov chain sampler by inverse-CDF search. Requests load one entry of the
// transition table or of the initial distribution, or carry a Q0.16 draw
// that picks the first state (start) or the next state from the current
// state's row (step); the pick is the first column whose running sum reaches
// the draw, clamped to num_states-1. Every request returns one response. A
// two-entry request queue feeds the execution unit, and a response register
// holds the result until popped. A load completes without a table walk once
// the response register is free; a draw walks its row from column zero,
// reading one table entry per cycle from the table memory, up to the chosen
// state. num_states should be written only while the block is idle; tables
// hold no reset value and must be loaded before use.

module markov_chain_state_sampler_core
   import mcss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [1:0]            req_mode,
   input  logic [STATE_BITS-1:0] req_row_index,
   input  logic [STATE_BITS-1:0] req_col_index,
   input  logic [PROB_BITS-1:0]  req_probability,
   input  logic [PROB_BITS-1:0]  req_random_draw,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [STATE_BITS-1:0] rsp_drawn_state,
   output logic                  rsp_is_draw,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [NUM_BITS-1:0]   csr_num_states
);

   logic [NUM_BITS-1:0] num_states_ff;
   fq_head_type         head;
   logic                head_pop;

   // Configuration register.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_states_ff <= NUM_STATES_RESET;
      end else if (csr_valid && csr_ready) begin
         num_states_ff <= csr_num_states;
      end
   end

   // Request intake and queue.
   mcss_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_mode        (req_mode),
      .req_row_index   (req_row_index),
      .req_col_index   (req_col_index),
      .req_probability (req_probability),
      .req_random_draw (req_random_draw),
      .head            (head),
      .head_pop        (head_pop)
   );

   // Execution unit with the tables.
   mcss_back u_back (
      .clock           (clock),
      .reset           (reset),
      .num_states      (num_states_ff),
      .head            (head),
      .head_pop        (head_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_drawn_state (rsp_drawn_state),
      .rsp_is_draw     (rsp_is_draw)
   );

endmodule

// File: rtl/core/mcss_ram.sv
`timescale 1ns / 1ps

module mcss_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// File: rtl/core/mcss_front.sv
`timescale 1ns / 1ps

module mcss_front
   import mcss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [1:0]            req_mode,
   input  logic [STATE_BITS-1:0] req_row_index,
   input  logic [STATE_BITS-1:0] req_col_index,
   input  logic [PROB_BITS-1:0]  req_probability,
   input  logic [PROB_BITS-1:0]  req_random_draw,
   output fq_head_type           head,
   input  logic                  head_pop
);

   cmd_type                 q_ff [FQ_DEPTH];
   logic [FQ_PTR_BITS-1:0]  wr_ptr_ff;
   logic [FQ_PTR_BITS-1:0]  rd_ptr_ff;
   logic [FQ_PTR_BITS:0]    count_ff;
   cmd_type                 cmd;
   logic                    push_ok;
   logic                    pop_ok;
   logic                    row_ok;
   logic                    col_ok;

   // Classify the incoming request and check its load indexes.
   always_comb begin
      row_ok = {1'b0, req_row_index} < STATE_LIMIT;
      col_ok = {1'b0, req_col_index} < STATE_LIMIT;
      cmd.op = op_type'(req_mode);
      cmd.row = req_row_index;
      cmd.col = req_col_index;
      cmd.prob = req_probability;
      cmd.draw = req_random_draw;
      case (cmd.op)
         OP_LOAD_TRANS: cmd.load_ok = row_ok && col_ok;
         OP_LOAD_INIT:  cmd.load_ok = col_ok;
         default:       cmd.load_ok = 1'b0;
      endcase
   end

   assign req_full = (count_ff == (FQ_PTR_BITS + 1)'(FQ_DEPTH));
   assign push_ok = req_push && !req_full;
   assign pop_ok = head_pop && head.valid;
   assign head.valid = (count_ff != '0);
   assign head.cmd = q_ff[rd_ptr_ff];

   // Queue storage and pointers.
   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= cmd;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push_ok) begin
            wr_ptr_ff <= wr_ptr_ff + FQ_PTR_BITS'(1);
         end
         if (pop_ok) begin
            rd_ptr_ff <= rd_ptr_ff + FQ_PTR_BITS'(1);
         end
         if (push_ok && !pop_ok) begin
            count_ff <= count_ff + (FQ_PTR_BITS + 1)'(1);
         end else if (pop_ok && !push_ok) begin
            count_ff <= count_ff - (FQ_PTR_BITS + 1)'(1);
         end
      end
   end

endmodule

// File: rtl/core/mcss_back.sv
`timescale 1ns / 1ps

module mcss_back
   import mcss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [NUM_BITS-1:0]   num_states,
   input  fq_head_type           head,
   output logic                  head_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [STATE_BITS-1:0] rsp_drawn_state,
   output logic                  rsp_is_draw
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_WAIT
   } state_type;

   state_type               state_ff, state_in;
   logic [STATE_BITS-1:0]   cur_ff, cur_in;
   logic [STATE_BITS-1:0]   src_ff, src_in;
   logic [STATE_BITS-1:0]   idx_ff, idx_in;
   logic [STATE_BITS-1:0]   res_ff, res_in;
   logic                    sel_init_ff, sel_init_in;
   logic [SUM_BITS-1:0]     sum_ff, sum_in;
   logic [PROB_BITS-1:0]    draw_ff, draw_in;
   logic                    out_valid_ff, out_valid_in;
   logic [STATE_BITS-1:0]   out_state_ff, out_state_in;
   logic                    out_is_draw_ff, out_is_draw_in;

   logic                    tt_we;
   logic [TT_ADDR_BITS-1:0] tt_waddr;
   logic [TT_ADDR_BITS-1:0] tt_raddr;
   logic [PROB_BITS-1:0]    tt_rdata;
   logic                    it_we;
   logic [STATE_BITS-1:0]   it_raddr;
   logic [PROB_BITS-1:0]    it_rdata;

   logic [LIM_BITS-1:0]     num_ext;
   logic [LIM_BITS-1:0]     lim_ext;
   logic [STATE_BITS-1:0]   last_idx;
   logic [SUM_BITS-1:0]     sum_next;
   logic                    hit;
   logic                    slot_free;
   logic [STATE_BITS-1:0]   idx_plus;

   // Tables.
   mcss_ram #(
      .WIDTH (PROB_BITS),
      .DEPTH (TT_DEPTH)
   ) u_trans_ram (
      .clock   (clock),
      .wr_en   (tt_we),
      .wr_addr (tt_waddr),
      .wr_data (head.cmd.prob),
      .rd_addr (tt_raddr),
      .rd_data (tt_rdata)
   );

   mcss_ram #(
      .WIDTH (PROB_BITS),
      .DEPTH (IT_DEPTH)
   ) u_init_ram (
      .clock   (clock),
      .wr_en   (it_we),
      .wr_addr (head.cmd.col),
      .wr_data (head.cmd.prob),
      .rd_addr (it_raddr),
      .rd_data (it_rdata)
   );

   // Last searched column: num_states - 1, with zero read as one and
   // values above the table size saturated.
   always_comb begin
      num_ext = LIM_BITS'(num_states);
      lim_ext = LIM_BITS'(MAX_STATES);
      if (num_ext == '0) begin
         last_idx = '0;
      end else if (num_ext > lim_ext) begin
         last_idx = STATE_BITS'(lim_ext - LIM_BITS'(1));
      end else begin
         last_idx = STATE_BITS'(num_ext - LIM_BITS'(1));
      end
   end

   // Running sum and hit test for the entry read in the previous cycle.
   assign sum_next = sum_ff + SUM_BITS'(sel_init_ff ? it_rdata : tt_rdata);
   assign hit = (SUM_BITS'(draw_ff) <= sum_next) || (idx_ff == last_idx);
   assign slot_free = !out_valid_ff || rsp_pop;
   assign idx_plus = idx_ff + STATE_BITS'(1);
   assign tt_waddr = {head.cmd.row, head.cmd.col};

   // Sequencer: loads finish in the idle state once the response slot is free, draws walk one row entry per cycle.
   always_comb begin
      state_in = state_ff;
      cur_in = cur_ff;
      src_in = src_ff;
      idx_in = idx_ff;
      res_in = res_ff;
      sel_init_in = sel_init_ff;
      sum_in = sum_ff;
      draw_in = draw_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_state_in = out_state_ff;
      out_is_draw_in = out_is_draw_ff;
      head_pop = 1'b0;
      tt_we = 1'b0;
      it_we = 1'b0;
      tt_raddr = {src_ff, idx_plus};
      it_raddr = idx_plus;

      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               case (head.cmd.op)
                  OP_LOAD_TRANS, OP_LOAD_INIT: begin
                     if (slot_free) begin
                        head_pop = 1'b1;
                        tt_we = head.cmd.load_ok && (head.cmd.op == OP_LOAD_TRANS);
                        it_we = head.cmd.load_ok && (head.cmd.op == OP_LOAD_INIT);
                        out_valid_in = 1'b1;
                        out_state_in = cur_ff;
                        out_is_draw_in = 1'b0;
                     end
                  end
                  default: begin
                     // Start or step: read column zero of the chosen row.
                     head_pop = 1'b1;
                     sel_init_in = (head.cmd.op == OP_START);
                     src_in = cur_ff;
                     idx_in = '0;
                     sum_in = '0;
                     draw_in = head.cmd.draw;
                     tt_raddr = {cur_ff, STATE_BITS'(0)};
                     it_raddr = '0;
                     state_in = ST_SEARCH;
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            sum_in = sum_next;
            idx_in = idx_plus;
            if (hit) begin
               cur_in = idx_ff;
               res_in = idx_ff;
               if (slot_free) begin
                  out_valid_in = 1'b1;
                  out_state_in = idx_ff;
                  out_is_draw_in = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_WAIT;
               end
            end
         end
         ST_WAIT: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_state_in = res_ff;
               out_is_draw_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and result register.
   always_ff @(posedge clock) begin
      src_ff <= src_in;
      idx_ff <= idx_in;
      res_ff <= res_in;
      sel_init_ff <= sel_init_in;
      sum_ff <= sum_in;
      draw_ff <= draw_in;
      out_state_ff <= out_state_in;
      out_is_draw_ff <= out_is_draw_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         cur_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cur_ff <= cur_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_drawn_state = out_state_ff;
   assign rsp_is_draw = out_is_draw_ff;

endmodule
